/* rtl/core/fpr_pkg.sv */
`default_nettype none

package fpr_pkg;

  // Fixed field widths of the streams and the register
  localparam int PAGE_W    = 4;
  localparam int FRAME_O_W = 3;
  localparam int TOTAL_W   = 16;
  localparam int FIU_W     = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 80;

  // Configuration register map (word index = paddr[2])
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_FRAMES_IN_USE = 1'b0;
  localparam logic [FIU_W-1:0] FIU_RESET = 4'd8;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } fpr_state_t;

  // Access request to one of the stores
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } fpr_mem_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/fifo_page_replacement.sv */
`default_nettype none

// FIFO page replacement unit. Each request on the in_ stream is one page
// reference; the out_ stream returns one result per request with hit/miss,
// the victim page, the frame now holding the page, the hit/miss/eviction
// totals and the page's reference count (all saturating). For each item,
// the idle state issues the first frame read and the histogram read, the
// frame RAM is then walked one entry per cycle until a hit or the last
// active frame, and the done state writes back frame, histogram and
// counters once the result register is free. One item is processed at a
// time; the result register lets the next request enter while a result is
// still waiting. After reset the histogram RAM is cleared entry by entry,
// during which in_tready stays low (register writes are taken).
// frames_in_use (byte address 0) of 0 acts as 1 and values above
// MAX_FRAMES act as MAX_FRAMES.
module fifo_page_replacement
  import fpr_pkg::*;
#(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_COUNT = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // request stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [3:0] page_number
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [0] hit, [1] evicted,
                                                  // [5:2] victim_page,
                                                  // [8:6] frame_index,
                                                  // [24:9] hit_total,
                                                  // [40:25] miss_total,
                                                  // [56:41] evict_total,
                                                  // [72:57] page_ref_total
  // configuration
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [31:0]            cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NUM_W  = $clog2(MAX_FRAMES + 1);
  localparam int HIDX_W = $clog2(PAGE_COUNT);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  fpr_state_t state_r, state_nxt;

  // Configuration register
  logic [FIU_W-1:0] frames_in_use_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_FRAMES_IN_USE) ? 32'(frames_in_use_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= FIU_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_FRAMES_IN_USE) begin
      frames_in_use_r <= cfg_pwdata[FIU_W-1:0];
    end
  end

  // Active frame count and its last index
  logic [NUM_W-1:0]  num_frames;
  logic [FIDX_W-1:0] last_idx_c;

  always_comb begin
    if (frames_in_use_r == '0) begin
      num_frames = NUM_W'(1);
    end else if (32'(frames_in_use_r) > MAX_FRAMES) begin
      num_frames = NUM_W'(MAX_FRAMES);
    end else begin
      num_frames = NUM_W'(frames_in_use_r);
    end
    last_idx_c = FIDX_W'(num_frames - NUM_W'(1));
  end

  // Per-item working registers
  logic [PAGE_W-1:0]     page_r;
  logic                  page_ok_r;
  logic [FIDX_W-1:0]     last_idx_r;
  logic [FIDX_W-1:0]     ptr_eff_r;
  logic [FIDX_W-1:0]     fifo_ptr_r;
  logic [FIDX_W-1:0]     cmp_idx_r;
  logic                  hit_r;
  logic [FIDX_W-1:0]     hit_idx_r;
  logic                  victim_used_r;
  logic [PAGE_W-1:0]     victim_page_r;
  logic [COUNT_BITS-1:0] hit_cnt_r, miss_cnt_r, evict_cnt_r;

  logic                  in_fire;
  logic                  out_free;
  logic                  hist_busy;

  // Store interfaces
  fpr_mem_ctl_t          frm_ctl, hist_ctl;
  logic [FIDX_W-1:0]     frm_rd_addr;
  logic [PAGE_W-1:0]     frm_rd_page;
  logic                  frm_rd_used;
  logic [HIDX_W-1:0]     hist_addr;
  logic [COUNT_BITS-1:0] hist_rd_data, hist_new;

  // Scan compare on the entry read in the previous cycle
  logic scan_hit, scan_end;
  assign scan_hit = frm_rd_used && (frm_rd_page == page_r);
  assign scan_end = scan_hit || (cmp_idx_r == last_idx_r);

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_tvalid || out_tready;

  assign hist_new  = (hist_rd_data == CNT_MAX) ? hist_rd_data : hist_rd_data + 1'b1;
  assign hist_addr = in_fire ? HIDX_W'(in_tdata[PAGE_W-1:0]) : HIDX_W'(page_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_end) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready        = 1'b0;
    frm_ctl          = '0;
    hist_ctl         = '0;
    frm_rd_addr      = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready    = !hist_busy;
        frm_ctl.rd_en  = in_fire;
        hist_ctl.rd_en = in_fire && (32'(in_tdata[PAGE_W-1:0]) < PAGE_COUNT);
      end
      ST_SCAN: begin
        frm_ctl.rd_en = !scan_end;
        frm_rd_addr   = cmp_idx_r + 1'b1;
      end
      ST_DONE: begin
        frm_ctl.wr_en  = out_free && !hit_r;
        hist_ctl.wr_en = out_free && page_ok_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      page_r     <= in_tdata[PAGE_W-1:0];
      page_ok_r  <= 32'(in_tdata[PAGE_W-1:0]) < PAGE_COUNT;
      last_idx_r <= last_idx_c;
      ptr_eff_r  <= (fifo_ptr_r > last_idx_c) ? '0 : fifo_ptr_r;
      cmp_idx_r  <= '0;
    end else if (state_r == ST_SCAN) begin
      if (cmp_idx_r == ptr_eff_r) begin
        victim_used_r <= frm_rd_used;
        victim_page_r <= frm_rd_page;
      end
      if (scan_end) begin
        hit_r     <= scan_hit;
        hit_idx_r <= cmp_idx_r;
      end else begin
        cmp_idx_r <= cmp_idx_r + 1'b1;
      end
    end
  end

  // Counters, FIFO pointer and result register
  logic                  done_go;
  logic                  evict_c;
  logic [FIDX_W-1:0]     where_c;
  logic [COUNT_BITS-1:0] ref_c;

  assign done_go = (state_r == ST_DONE) && out_free;
  assign evict_c = !hit_r && victim_used_r;
  assign where_c = hit_r ? hit_idx_r : ptr_eff_r;
  assign ref_c   = page_ok_r ? hist_new : '0;

  logic [COUNT_BITS-1:0] hit_cnt_c, miss_cnt_c, evict_cnt_c;

  always_comb begin
    hit_cnt_c   = hit_cnt_r;
    miss_cnt_c  = miss_cnt_r;
    evict_cnt_c = evict_cnt_r;
    if (hit_r) begin
      if (hit_cnt_r != CNT_MAX) hit_cnt_c = hit_cnt_r + 1'b1;
    end else begin
      if (miss_cnt_r != CNT_MAX) miss_cnt_c = miss_cnt_r + 1'b1;
      if (evict_c && evict_cnt_r != CNT_MAX) evict_cnt_c = evict_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      fifo_ptr_r  <= '0;
      out_tvalid  <= 1'b0;
    end else begin
      if (done_go) begin
        hit_cnt_r   <= hit_cnt_c;
        miss_cnt_r  <= miss_cnt_c;
        evict_cnt_r <= evict_cnt_c;
        if (!hit_r) begin
          fifo_ptr_r <= (ptr_eff_r == last_idx_r) ? '0 : ptr_eff_r + 1'b1;
        end
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_tdata <= {7'd0,
                    TOTAL_W'(ref_c),
                    TOTAL_W'(evict_cnt_c),
                    TOTAL_W'(miss_cnt_c),
                    TOTAL_W'(hit_cnt_c),
                    FRAME_O_W'(where_c),
                    evict_c ? victim_page_r : 4'd0,
                    evict_c,
                    hit_r};
    end
  end

  fpr_frame_store #(
    .MAX_FRAMES (MAX_FRAMES),
    .FIDX_W     (FIDX_W)
  ) u_frame_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (frm_ctl),
    .rd_addr   (frm_rd_addr),
    .wr_addr   (ptr_eff_r),
    .wr_page   (page_r),
    .rd_page_r (frm_rd_page),
    .rd_used_r (frm_rd_used)
  );

  fpr_hist_store #(
    .PAGE_COUNT (PAGE_COUNT),
    .HIDX_W     (HIDX_W),
    .COUNT_BITS (COUNT_BITS)
  ) u_hist_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (hist_ctl),
    .addr      (hist_addr),
    .wr_data   (hist_new),
    .rd_data_r (hist_rd_data),
    .busy      (hist_busy)
  );

endmodule

`default_nettype wire

/* rtl/core/fpr_frame_store.sv */
`default_nettype none

module fpr_frame_store
  import fpr_pkg::*;
#(
  parameter int MAX_FRAMES = 8,
  parameter int FIDX_W     = 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fpr_mem_ctl_t      ctl,
  input  wire logic [FIDX_W-1:0] rd_addr,
  input  wire logic [FIDX_W-1:0] wr_addr,
  input  wire logic [PAGE_W-1:0] wr_page,
  output logic [PAGE_W-1:0]      rd_page_r,
  output logic                   rd_used_r
);

  // Page numbers in a synchronous RAM, occupancy in flops cleared by reset
  logic [PAGE_W-1:0]     page_mem [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] used_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      page_mem[wr_addr] <= wr_page;
    end
    if (ctl.rd_en) begin
      rd_page_r <= page_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      rd_used_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        used_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_used_r <= used_r[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fpr_hist_store.sv */
`default_nettype none

module fpr_hist_store
  import fpr_pkg::*;
#(
  parameter int PAGE_COUNT = 16,
  parameter int HIDX_W     = 4,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire fpr_mem_ctl_t          ctl,
  input  wire logic [HIDX_W-1:0]     addr,
  input  wire logic [COUNT_BITS-1:0] wr_data,
  output logic [COUNT_BITS-1:0]      rd_data_r,
  output logic                       busy
);

  localparam logic [HIDX_W-1:0] LAST_IDX = HIDX_W'(PAGE_COUNT - 1);

  logic [COUNT_BITS-1:0] hist_mem [PAGE_COUNT];
  logic [HIDX_W-1:0]     clr_idx_r;
  logic                  clr_busy_r;

  assign busy = clr_busy_r;

  // Clearing sweep after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == LAST_IDX) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Single-port RAM, read data registered and held between reads
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      hist_mem[clr_idx_r] <= '0;
    end else if (ctl.wr_en) begin
      hist_mem[addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= hist_mem[addr];
    end
  end

endmodule

`default_nettype wire
